@@ rtl/ctb_pkg.sv @@
package ctb_pkg;

    // Fixed field widths of the item and result beats.
    localparam int ACTION_W = 3;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 9;
    localparam int COUNT_W  = 10;

    // Action codes carried on the input channel.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LEFT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RIGHT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    // Decoded operation held between the read and the write-back cycle.
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DELETE,
        OP_LEFT,
        OP_RIGHT,
        OP_READ,
        OP_NONE
    } ctb_op_t;

    typedef struct packed {
        ctb_op_t op;
        logic    ignored;
        logic    sel_before;
    } ctb_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctb_state_t;

endpackage

@@ rtl/ctb_ram.sv @@
module ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/cursor_text_buffer.sv @@
// Text buffer with an edit cursor, kept as a gap buffer in two stack RAMs.
// An accepted item is latched with its RAM reads; EXEC writes back and registers the result.
// No new item is taken until EXEC is done; the RAM read comes before the write-back.
// A result beat held by the output stall keeps the input stalled until it is taken.
// Reset clears the byte counts, the control state and the output valid flag.
// RAM contents are not cleared; only entries below the counts are ever used.
module cursor_text_buffer #(
    parameter int DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ctb_pkg::ACTION_W-1:0]  action,
    input  logic [ctb_pkg::CHAR_W-1:0]    char_in,
    input  logic [ctb_pkg::INDEX_W-1:0]   read_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ctb_pkg::CHAR_W-1:0]    char_out,
    output logic [ctb_pkg::COUNT_W-1:0]   text_length,
    output logic [ctb_pkg::COUNT_W-1:0]   cursor_pos,
    output logic                          ignored
);

    import ctb_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    ctb_state_t state_reg, state_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [CW-1:0] ac_reg, ac_next;
    ctb_cmd_t cmd_reg, cmd_next;
    logic [CHAR_W-1:0] char_reg;

    logic out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_out_reg, char_out_next;
    logic [COUNT_W-1:0] len_out_reg, len_out_next;
    logic [COUNT_W-1:0] cur_out_reg, cur_out_next;
    logic ign_out_reg, ign_out_next;

    logic in_accept;
    logic [CW-1:0] len;
    logic [CW-1:0] bc_dec;
    logic [CW-1:0] ac_dec;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] bc_ext;
    logic [CMPW-1:0] len_ext;
    logic [CMPW-1:0] rev_pos;
    logic [CW-1:0] len_next;
    logic [COUNT_W+CW-1:0] len_wide;
    logic [COUNT_W+CW-1:0] cur_wide;

    logic before_wr_en, after_wr_en;
    logic [AW-1:0] before_rd_addr, after_rd_addr;
    logic [CHAR_W-1:0] before_wr_data;
    logic [CHAR_W-1:0] before_rd_data, after_rd_data;

    // Bytes before the cursor, in order.
    ctb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_before_ram (
        .clk     (clk),
        .wr_en   (before_wr_en),
        .wr_addr (bc_reg[AW-1:0]),
        .wr_data (before_wr_data),
        .rd_en   (in_accept),
        .rd_addr (before_rd_addr),
        .rd_data (before_rd_data)
    );

    // Bytes after the cursor, reversed: the top entry is next to the cursor.
    ctb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_after_ram (
        .clk     (clk),
        .wr_en   (after_wr_en),
        .wr_addr (ac_reg[AW-1:0]),
        .wr_data (before_rd_data),
        .rd_en   (in_accept),
        .rd_addr (after_rd_addr),
        .rd_data (after_rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    // Address and edge-case decode for the incoming beat.
    always_comb
    begin
        len     = bc_reg + ac_reg;
        bc_dec  = bc_reg - CW'(1);
        ac_dec  = ac_reg - CW'(1);
        idx_ext = CMPW'(read_index);
        bc_ext  = CMPW'(bc_reg);
        len_ext = CMPW'(len);
        rev_pos = len_ext - idx_ext - CMPW'(1);

        before_rd_addr = (action == ACT_LEFT) ? bc_dec[AW-1:0] : rev_pos[AW-1:0];
        if (action != ACT_LEFT)
        begin
            before_rd_addr = idx_ext[AW-1:0];
        end
        after_rd_addr = (action == ACT_RIGHT) ? ac_dec[AW-1:0] : rev_pos[AW-1:0];

        cmd_next.sel_before = (idx_ext < bc_ext);
        case (action)
            ACT_INSERT:
            begin
                cmd_next.op      = OP_INSERT;
                cmd_next.ignored = (len >= CW'(DEPTH));
            end
            ACT_DELETE:
            begin
                cmd_next.op      = OP_DELETE;
                cmd_next.ignored = (bc_reg == '0);
            end
            ACT_LEFT:
            begin
                cmd_next.op      = OP_LEFT;
                cmd_next.ignored = (bc_reg == '0) || (ac_reg >= CW'(DEPTH));
            end
            ACT_RIGHT:
            begin
                cmd_next.op      = OP_RIGHT;
                cmd_next.ignored = (ac_reg == '0) || (bc_reg >= CW'(DEPTH));
            end
            ACT_READ:
            begin
                cmd_next.op      = OP_READ;
                cmd_next.ignored = (idx_ext >= len_ext);
            end
            default:
            begin
                cmd_next.op      = OP_NONE;
                cmd_next.ignored = 1'b1;
            end
        endcase
    end

    // Sequencer: write-back, count update and result load.
    always_comb
    begin
        state_next     = state_reg;
        bc_next        = bc_reg;
        ac_next        = ac_reg;
        before_wr_en   = 1'b0;
        after_wr_en    = 1'b0;
        before_wr_data = (cmd_reg.op == OP_INSERT) ? char_reg : after_rd_data;
        out_valid_next = out_valid_reg && out_stall;
        char_out_next  = char_out_reg;
        ign_out_next   = ign_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                ign_out_next   = cmd_reg.ignored;
                char_out_next  = '0;
                if (!cmd_reg.ignored)
                begin
                    case (cmd_reg.op)
                        OP_INSERT:
                        begin
                            before_wr_en = 1'b1;
                            bc_next      = bc_reg + CW'(1);
                        end
                        OP_DELETE:
                        begin
                            bc_next = bc_dec;
                        end
                        OP_LEFT:
                        begin
                            after_wr_en = 1'b1;
                            bc_next     = bc_dec;
                            ac_next     = ac_reg + CW'(1);
                        end
                        OP_RIGHT:
                        begin
                            before_wr_en = 1'b1;
                            ac_next      = ac_dec;
                            bc_next      = bc_reg + CW'(1);
                        end
                        OP_READ:
                        begin
                            char_out_next = cmd_reg.sel_before ? before_rd_data
                                                               : after_rd_data;
                        end
                        default:
                        begin
                            char_out_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        len_next     = bc_next + ac_next;
        len_wide     = {{COUNT_W{1'b0}}, len_next};
        cur_wide     = {{COUNT_W{1'b0}}, bc_next};
        len_out_next = (state_reg == ST_EXEC) ? len_wide[COUNT_W-1:0] : len_out_reg;
        cur_out_next = (state_reg == ST_EXEC) ? cur_wide[COUNT_W-1:0] : cur_out_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            ac_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            ac_reg        <= ac_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Accepted beat and result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= cmd_next;
            char_reg <= char_in;
        end
        char_out_reg <= char_out_next;
        len_out_reg  <= len_out_next;
        cur_out_reg  <= cur_out_next;
        ign_out_reg  <= ign_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign text_length = len_out_reg;
    assign cursor_pos  = cur_out_reg;
    assign ignored     = ign_out_reg;

endmodule

@@ sim/ctb_checker.sv @@
// Watches both channels of the text buffer, predicts every result beat and
// compares it with what the block returns.
module ctb_checker #(
    parameter int DEPTH = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [ctb_pkg::ACTION_W-1:0] action,
    input  logic [ctb_pkg::CHAR_W-1:0]   char_in,
    input  logic [ctb_pkg::INDEX_W-1:0]  read_index,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [ctb_pkg::CHAR_W-1:0]   char_out,
    input  logic [ctb_pkg::COUNT_W-1:0]  text_length,
    input  logic [ctb_pkg::COUNT_W-1:0]  cursor_pos,
    input  logic                         ignored,
    output int                           mismatch_count,
    output int                           outstanding
);

    import ctb_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] len;
        logic [COUNT_W-1:0] cur;
        logic               ign;
    } edit_result_t;

    // Expected result beats, oldest first.
    edit_result_t expected_q[$];

    // Shadow gap buffer: text before the cursor in order, text after it reversed.
    logic [CHAR_W-1:0] before_bytes [DEPTH];
    logic [CHAR_W-1:0] after_bytes  [DEPTH];
    int                before_len;
    int                after_len;

    // Applies one edit action to the shadow buffer and returns its result beat.
    function automatic edit_result_t apply_action(
        input logic [ACTION_W-1:0] act,
        input logic [CHAR_W-1:0]   ch,
        input logic [INDEX_W-1:0]  idx
    );
        edit_result_t res;
        int           len;
        int           pos;
        res = '0;
        len = before_len + after_len;
        pos = int'(idx);
        case (act)
            ACT_INSERT:
            begin
                if (len >= DEPTH) begin
                    res.ign = 1'b1;
                end else begin
                    before_bytes[before_len] = ch;
                    before_len++;
                end
            end
            ACT_DELETE:
            begin
                if (before_len == 0) res.ign = 1'b1;
                else before_len--;
            end
            ACT_LEFT:
            begin
                if (before_len == 0 || after_len >= DEPTH) begin
                    res.ign = 1'b1;
                end else begin
                    before_len--;
                    after_bytes[after_len] = before_bytes[before_len];
                    after_len++;
                end
            end
            ACT_RIGHT:
            begin
                if (after_len == 0 || before_len >= DEPTH) begin
                    res.ign = 1'b1;
                end else begin
                    after_len--;
                    before_bytes[before_len] = after_bytes[after_len];
                    before_len++;
                end
            end
            ACT_READ:
            begin
                if (pos < before_len) res.ch = before_bytes[pos];
                else if (pos < len) res.ch = after_bytes[after_len - 1 - (pos - before_len)];
                else res.ign = 1'b1;
            end
            default:
            begin
                res.ign = 1'b1;
            end
        endcase
        res.len = COUNT_W'(before_len + after_len);
        res.cur = COUNT_W'(before_len);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare each result beat with the oldest expectation, then predict
    // the result of each accepted item beat.
    always @(posedge clk or negedge rst_n)
    begin
        edit_result_t want;
        if (!rst_n) begin
            expected_q.delete();
            before_len = 0;
            after_len = 0;
            mismatch_count = 0;
            outstanding <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with no expectation waiting");
                end else begin
                    want = expected_q.pop_front();
                    if (char_out !== want.ch)
                        report_mismatch($sformatf("char_out got %0h want %0h",
                                                  char_out, want.ch));
                    if (text_length !== want.len)
                        report_mismatch($sformatf("text_length got %0d want %0d",
                                                  text_length, want.len));
                    if (cursor_pos !== want.cur)
                        report_mismatch($sformatf("cursor_pos got %0d want %0d",
                                                  cursor_pos, want.cur));
                    if (ignored !== want.ign)
                        report_mismatch($sformatf("ignored got %0b want %0b",
                                                  ignored, want.ign));
                end
            end
            if (in_valid && !in_stall) begin
                expected_q.push_back(apply_action(action, char_in, read_index));
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

@@ sim/tb_cursor_text_buffer.sv @@
// Drives edit actions into the text buffer and gives the verdict; all
// prediction and checking sits in the checker beside the block.
module tb_cursor_text_buffer;
    import ctb_pkg::*;

    localparam int DEPTH           = 512;
    localparam int IDLE_PCT        = 15;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int FILL_INSERTS    = 530;
    localparam int DRAIN_BEATS     = 600;
    localparam int CALM_BEATS      = 250;
    localparam int MIXED_BEATS     = 450;

    // Highest action code; the codes above ACT_READ are unused.
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST = 3'd7;
    localparam logic [CHAR_W-1:0]   CH_NEWLINE     = 8'd10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic [CHAR_W-1:0]   char_in = '0;
    logic [INDEX_W-1:0]  read_index = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CHAR_W-1:0]   char_out;
    logic [COUNT_W-1:0]  text_length;
    logic [COUNT_W-1:0]  cursor_pos;
    logic                ignored;

    logic                calm = 1'b0;
    logic                hold_off_req = 1'b0;
    int                  mismatch_count;
    int                  outstanding;

    always #5 clk = ~clk;

    cursor_text_buffer #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .char_in     (char_in),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .text_length (text_length),
        .cursor_pos  (cursor_pos),
        .ignored     (ignored)
    );

    ctb_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .char_in        (char_in),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_out       (char_out),
        .text_length    (text_length),
        .cursor_pos     (cursor_pos),
        .ignored        (ignored),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Offers one item beat, with random idle cycles ahead of it, and returns
    // at the edge where it is accepted. Valid stays high for a following beat.
    task automatic send_beat(
        input logic [ACTION_W-1:0] act,
        input logic [CHAR_W-1:0]   ch,
        input logic [INDEX_W-1:0]  idx
    );
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        char_in    <= ch;
        read_index <= idx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Mostly indexes near the start of the text, sometimes anywhere; always anywhere when wide is set.
    function automatic logic [INDEX_W-1:0] rand_index(input bit wide);
        if (wide || $urandom_range(0, 99) < 30) return INDEX_W'($urandom_range(0, 511));
        return INDEX_W'($urandom_range(0, 63));
    endfunction

    // Weighted action choice; whatever weight is left goes to unused codes.
    function automatic logic [ACTION_W-1:0] pick_action(
        input int w_ins,
        input int w_del,
        input int w_left,
        input int w_right,
        input int w_read
    );
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins) return ACT_INSERT;
        r -= w_ins;
        if (r < w_del) return ACT_DELETE;
        r -= w_del;
        if (r < w_left) return ACT_LEFT;
        r -= w_left;
        if (r < w_right) return ACT_RIGHT;
        r -= w_right;
        if (r < w_read) return ACT_READ;
        return ACTION_W'($urandom_range(int'(ACT_READ) + 1, int'(ACT_SPARE_LAST)));
    endfunction

    task automatic send_random_beat(input logic [ACTION_W-1:0] act, input bit wide);
        send_beat(act, CHAR_W'($urandom_range(0, 255)), rand_index(wide));
    endtask

    // Stops offering until every expected result beat has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Receiver stall: random stalls, one long hold-off on request, none
    // while the calm stretch is on.
    initial
    begin : result_stall_gen
        int hold_cnt;
        bit hold_done;
        hold_cnt = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cnt > 0) begin
                out_stall <= 1'b1;
                hold_cnt--;
            end else if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt = HOLD_OFF_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a beat for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int inserts_left;
        int r;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Edges of the empty buffer, and the unused action codes.
        send_beat(ACT_DELETE, 8'h00, 9'd0);
        send_beat(ACT_LEFT, 8'h00, 9'd0);
        send_beat(ACT_RIGHT, 8'hFF, 9'd0);
        send_beat(ACT_READ, 8'h00, 9'd0);
        send_beat(ACT_READ, 8'hFF, 9'd511);
        for (int c = int'(ACT_READ) + 1; c <= int'(ACT_SPARE_LAST); c++)
            send_beat(ACTION_W'(c), 8'hA5, 9'h155);

        // Small edits around the cursor, with reads on both sides of it.
        send_beat(ACT_INSERT, 8'h00, 9'd0);
        send_beat(ACT_INSERT, 8'hFF, 9'd0);
        send_beat(ACT_INSERT, CH_NEWLINE, 9'd0);
        send_beat(ACT_LEFT, 8'h00, 9'd0);
        send_beat(ACT_LEFT, 8'h00, 9'd0);
        send_beat(ACT_READ, 8'h00, 9'd0);
        send_beat(ACT_READ, 8'h00, 9'd1);
        send_beat(ACT_READ, 8'h00, 9'd2);
        send_beat(ACT_READ, 8'h00, 9'd3);
        send_beat(ACT_INSERT, 8'h55, 9'd0);
        send_beat(ACT_READ, 8'h00, 9'd1);
        send_beat(ACT_RIGHT, 8'h00, 9'd0);
        send_beat(ACT_RIGHT, 8'h00, 9'd0);
        send_beat(ACT_RIGHT, 8'h00, 9'd0);
        send_beat(ACT_DELETE, 8'h00, 9'd0);
        send_beat(ACT_READ, 8'h00, 9'd2);
        wait_drained();

        // Fill the buffer to the top while the receiver holds off for a
        // long stretch, so the block backs up and stalls its input.
        hold_off_req <= 1'b1;
        inserts_left = FILL_INSERTS;
        while (inserts_left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_random_beat(r < 4 ? ACT_LEFT : ACT_RIGHT, 1'b1);
            end else if (r < 14) begin
                send_random_beat(ACT_READ, 1'b1);
            end else begin
                send_random_beat(ACT_INSERT, 1'b1);
                inserts_left--;
            end
        end

        // Full buffer: inserts are dropped, the last index is readable.
        send_random_beat(ACT_INSERT, 1'b0);
        send_beat(ACT_READ, 8'h00, 9'd511);
        send_beat(ACT_READ, 8'h00, 9'd0);
        send_beat(ACT_LEFT, 8'h00, 9'd0);
        send_random_beat(ACT_INSERT, 1'b0);
        send_beat(ACT_READ, 8'h00, 9'd510);
        wait_drained();

        // Mostly deletes to shrink the text; the first part runs with no
        // idling on either side.
        calm <= 1'b1;
        for (int i = 0; i < DRAIN_BEATS; i++) begin
            if (i == CALM_BEATS) calm <= 1'b0;
            send_random_beat(pick_action(2, 70, 5, 15, 8), 1'b0);
        end
        wait_drained();

        // Balanced mix that keeps the text short and hits both edges.
        for (int i = 0; i < MIXED_BEATS; i++)
            send_random_beat(pick_action(28, 30, 17, 16, 7), 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
